FILE: sv/ssjac_pkg.sv
`timescale 1ns / 1ps
package ssjac_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND_A = 2'd0,
    KIND_APPEND_B = 2'd1,
    KIND_COMPARE  = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  localparam int COMMON_W = 11;
  localparam int UNION_W  = 12;
  localparam int RATIO_W  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } bk_state_t;

  typedef struct packed {
    logic   is_cmp;
    logic   sel_b;
    logic   ovf;
  } req_ctl_t;

endpackage

FILE: sv/ssjac_front.sv
`timescale 1ns / 1ps
// Classifies requests, writes set stores' addresses/data, queues compares.
module ssjac_front #(
  parameter int MAX_SET_SIZE = 1024,
  parameter int ID_WIDTH     = 32,
  localparam int CW = $clog2(MAX_SET_SIZE + 1),
  localparam int AW = $clog2(MAX_SET_SIZE)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [31:0]         in_element_id,
  // store write port
  output logic                wr_en,
  output logic                wr_sel_b,
  output logic [AW-1:0]       wr_addr,
  output logic [ID_WIDTH-1:0] wr_data,
  // back end is walking the stores
  input  logic                merge_busy,
  // queue to back end: one compare slot
  output logic                q_valid,
  input  logic                q_ready,
  output logic [CW-1:0]       q_cnt_a,
  output logic [CW-1:0]       q_cnt_b,
  output ssjac_pkg::req_ctl_t q_ctl
);

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          ovf_r, ovf_nxt;
  logic          busy_r, busy_nxt;
  logic          acc;
  logic          full_sel;
  logic [63:0]   id_ext;

  // while a compare is pending or being merged, the stores belong to the back end
  assign in_ready = !busy_r && !merge_busy;
  assign acc      = in_valid && in_ready;
  assign full_sel = (in_kind == ssjac_pkg::KIND_APPEND_B) ?
                    (cnt_b_r >= CW'(MAX_SET_SIZE)) : (cnt_a_r >= CW'(MAX_SET_SIZE));
  assign id_ext   = {32'd0, in_element_id};
  assign wr_data  = id_ext[ID_WIDTH-1:0];
  assign wr_sel_b = (in_kind == ssjac_pkg::KIND_APPEND_B);
  assign wr_addr  = wr_sel_b ? cnt_b_r[AW-1:0] : cnt_a_r[AW-1:0];
  assign wr_en    = acc && !full_sel && (in_kind == ssjac_pkg::KIND_APPEND_A ||
                    in_kind == ssjac_pkg::KIND_APPEND_B);

  assign q_valid      = busy_r;
  assign q_cnt_a      = cnt_a_r;
  assign q_cnt_b      = cnt_b_r;
  assign q_ctl.is_cmp = 1'b1;
  assign q_ctl.sel_b  = 1'b0;
  assign q_ctl.ovf    = ovf_r;

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ovf_nxt   = ovf_r;
    busy_nxt  = busy_r;
    if (busy_r && q_ready) begin
      busy_nxt  = 1'b0;
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (acc) begin
      case (in_kind)
        ssjac_pkg::KIND_APPEND_A: begin
          if (full_sel) ovf_nxt = 1'b1;
          else cnt_a_nxt = cnt_a_r + 1'b1;
        end
        ssjac_pkg::KIND_APPEND_B: begin
          if (full_sel) ovf_nxt = 1'b1;
          else cnt_b_nxt = cnt_b_r + 1'b1;
        end
        ssjac_pkg::KIND_COMPARE: busy_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_a_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(MAX_SET_SIZE)) else $error("set A count past capacity");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r || merge_busy) |-> !wr_en) else $error("store write during compare");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && q_ready) |=> (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r))
    else $error("sets not cleared after compare");
`endif

endmodule

FILE: sv/ssjac_back.sv
`timescale 1ns / 1ps
// Two-pointer merge over both stores, then restoring divide, then output register.
module ssjac_back #(
  parameter int MAX_SET_SIZE = 1024,
  parameter int ID_WIDTH     = 32,
  localparam int CW = $clog2(MAX_SET_SIZE + 1),
  localparam int AW = $clog2(MAX_SET_SIZE)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic                wr_sel_b,
  input  logic [AW-1:0]       wr_addr,
  input  logic [ID_WIDTH-1:0] wr_data,
  output logic                merge_busy,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [CW-1:0]       q_cnt_a,
  input  logic [CW-1:0]       q_cnt_b,
  input  ssjac_pkg::req_ctl_t q_ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [10:0]         out_common_count,
  output logic [11:0]         out_union_size,
  output logic [15:0]         out_jaccard_ratio,
  output logic                out_undefined_ratio,
  output logic                out_overflow_seen
);

  localparam int DW = CW + 17;  // dividend common<<16
  localparam int SW = $clog2(DW + 1);

  logic [ID_WIDTH-1:0] mem_a [MAX_SET_SIZE];
  logic [ID_WIDTH-1:0] mem_b [MAX_SET_SIZE];
  logic [ID_WIDTH-1:0] rd_a_r, rd_b_r;

  ssjac_pkg::bk_state_t st_r, st_nxt;
  logic [CW-1:0] pa_r, pa_nxt, pb_r, pb_nxt, na_r, nb_r;
  logic [CW-1:0] com_r, com_nxt;
  logic          ovf_r;
  logic [CW:0]   uni_r;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW+1:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CW+1:0] rem_sh;
  logic          more;
  logic [AW-1:0] ra, rb;
  logic          load;

  // one read per store per cycle, data registered
  assign ra = pa_nxt[AW-1:0];
  assign rb = pb_nxt[AW-1:0];
  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel_b) mem_a[wr_addr] <= wr_data;
    if (wr_en && wr_sel_b)  mem_b[wr_addr] <= wr_data;
    rd_a_r <= mem_a[ra];
    rd_b_r <= mem_b[rb];
  end

  assign q_ready    = (st_r == ssjac_pkg::ST_IDLE);
  assign merge_busy = (st_r == ssjac_pkg::ST_FETCH) || (st_r == ssjac_pkg::ST_CMP);
  assign load       = q_valid && q_ready && q_ctl.is_cmp;
  assign more       = (pa_r < na_r) && (pb_r < nb_r);
  assign rem_sh     = {rem_r[CW:0], quo_r[DW-1]};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ssjac_pkg::ST_IDLE:  if (load) st_nxt = ssjac_pkg::ST_FETCH;
      ssjac_pkg::ST_FETCH: st_nxt = ssjac_pkg::ST_CMP;
      ssjac_pkg::ST_CMP: begin
        if (!more) st_nxt = ssjac_pkg::ST_DIV;
        else st_nxt = ssjac_pkg::ST_FETCH;
      end
      ssjac_pkg::ST_DIV:   if (step_r == SW'(DW)) st_nxt = ssjac_pkg::ST_OUT;
      ssjac_pkg::ST_OUT:   if (out_ready) st_nxt = ssjac_pkg::ST_IDLE;
      default: st_nxt = ssjac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    com_nxt  = com_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    unique case (st_r)
      ssjac_pkg::ST_IDLE: begin
        pa_nxt  = '0;
        pb_nxt  = '0;
        com_nxt = '0;
      end
      ssjac_pkg::ST_CMP: begin
        if (more) begin
          if (rd_a_r < rd_b_r) pa_nxt = pa_r + 1'b1;
          else if (rd_b_r < rd_a_r) pb_nxt = pb_r + 1'b1;
          else begin
            pa_nxt  = pa_r + 1'b1;
            pb_nxt  = pb_r + 1'b1;
            com_nxt = com_r + 1'b1;
          end
        end else begin
          quo_nxt  = {1'b0, com_r, 16'd0};
          rem_nxt  = '0;
          step_nxt = '0;
        end
      end
      ssjac_pkg::ST_DIV: begin
        if (step_r != SW'(DW)) begin
          if (rem_sh >= {1'b0, uni_r}) begin
            rem_nxt = rem_sh - {1'b0, uni_r};
            quo_nxt = {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            quo_nxt = {quo_r[DW-2:0], 1'b0};
          end
          step_nxt = step_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ssjac_pkg::ST_IDLE;
    else st_r <= st_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    com_r  <= com_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (load) begin
      na_r  <= q_cnt_a;
      nb_r  <= q_cnt_b;
      ovf_r <= q_ctl.ovf;
    end
    if (st_r == ssjac_pkg::ST_CMP && !more)
      uni_r <= {1'b0, na_r} + {1'b0, nb_r} - {1'b0, com_r};
  end

  // zero divisor yields all-ones quotient; masked by undefined flag
  assign out_valid           = (st_r == ssjac_pkg::ST_OUT);
  assign out_common_count    = 11'(com_r);
  assign out_union_size      = 12'(uni_r);
  assign out_undefined_ratio = (uni_r == '0);
  assign out_jaccard_ratio   = out_undefined_ratio ? 16'd0 :
                               ((quo_r[DW-1:16] != '0) ? 16'hFFFF : quo_r[15:0]);
  assign out_overflow_seen   = ovf_r;

`ifndef ASSERT_OFF
  a_ptr_a: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ssjac_pkg::ST_CMP) |-> pa_r <= na_r) else $error("pointer A ran off");
  a_common: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ssjac_pkg::ST_OUT) |-> (com_r <= na_r && com_r <= nb_r))
    else $error("common exceeds set size");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(quo_r)) else $error("result moved in stall");
`endif

endmodule

FILE: sv/sorted_set_jaccard_similarity_core.sv
`timescale 1ns / 1ps
// Sorted-set Jaccard similarity core.
// Input channel (in_valid/in_ready, in_kind, in_element_id): each request
// appends an identifier to set A (kind 0) or set B (kind 1), or asks for a
// compare (kind 2). Kind 3 is accepted and ignored. Appends to a full set
// are dropped and remembered as overflow.
// Appends are accepted back to back while in_ready is high. A compare is
// queued to the back end, which walks both stores with a two-pointer merge
// (each step a registered store read, then a compare), then a restoring
// divide (one quotient bit per cycle), then the result is held. in_ready
// is low while a compare waits in the queue and while the merge reads the
// stores; the sets and overflow flag clear when the back end takes the
// compare, and appends resume once the merge ends.
// Output channel (out_valid/out_ready): one result per compare with common
// count, union size, Q0.16 ratio clamped to 65535, an undefined flag for an
// empty union and the overflow flag. If the receiver stalls, the result is
// held unchanged and further compares wait. Synchronous active-low reset
// empties both sets; the store contents are not cleared.
module sorted_set_jaccard_similarity_core #(
  parameter int MAX_SET_SIZE = 1024,
  parameter int ID_WIDTH     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_element_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_common_count,
  output logic [11:0] out_union_size,
  output logic [15:0] out_jaccard_ratio,
  output logic        out_undefined_ratio,
  output logic        out_overflow_seen
);

  localparam int CW = $clog2(MAX_SET_SIZE + 1);
  localparam int AW = $clog2(MAX_SET_SIZE);

  logic                wr_en, wr_sel_b;
  logic [AW-1:0]       wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic                merge_busy;
  logic                q_valid, q_ready;
  logic [CW-1:0]       q_cnt_a, q_cnt_b;
  ssjac_pkg::req_ctl_t q_ctl;

  ssjac_front #(.MAX_SET_SIZE(MAX_SET_SIZE), .ID_WIDTH(ID_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_element_id,
    .wr_en, .wr_sel_b, .wr_addr, .wr_data, .merge_busy,
    .q_valid, .q_ready, .q_cnt_a, .q_cnt_b, .q_ctl
  );

  ssjac_back #(.MAX_SET_SIZE(MAX_SET_SIZE), .ID_WIDTH(ID_WIDTH)) u_back (
    .clk, .rst_n, .wr_en, .wr_sel_b, .wr_addr, .wr_data, .merge_busy,
    .q_valid, .q_ready, .q_cnt_a, .q_cnt_b, .q_ctl,
    .out_valid, .out_ready, .out_common_count, .out_union_size,
    .out_jaccard_ratio, .out_undefined_ratio, .out_overflow_seen
  );

endmodule
